/* rtl/core/qcsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcsh_pkg
// Shared types and constants for the quadrature counter with stall homing.
// ----------------------------------------------------------------------------
package qcsh_pkg;

  // command carried in the input tuser
  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    REG_STALL_WINDOW = 1'b0,
    REG_SETTLE_MS    = 1'b1
  } reg_index_t;

  localparam int CFG_DATA_BITS   = 16;
  localparam int WINDOW_BITS     = 8;
  localparam int TIMER_BITS      = 16;

  localparam logic [WINDOW_BITS-1:0] STALL_WINDOW_RESET = 8'd2;
  localparam logic [TIMER_BITS-1:0]  SETTLE_MS_RESET    = 16'd2000;
  localparam logic [TIMER_BITS-1:0]  TIMER_MAX          = 16'hFFFF;

  localparam int COUNT_RESET        = -15000;
  localparam int LAST_CHECKED_RESET = 200;

  // quadrature histories that move the count up
  localparam logic [3:0] HIST_UP_A = 4'd2;
  localparam logic [3:0] HIST_UP_B = 4'd4;
  localparam logic [3:0] HIST_UP_C = 4'd11;
  localparam logic [3:0] HIST_UP_D = 4'd13;

  typedef struct packed {
    logic settle_armed;
    logic homed_now;
    logic calibrated;
  } qcsh_status_t;

  // previous pair in bits 3..2, new pair in bits 1..0
  function automatic logic quad_up(input logic [3:0] hist);
    quad_up = (hist == HIST_UP_A) || (hist == HIST_UP_B) ||
              (hist == HIST_UP_C) || (hist == HIST_UP_D);
  endfunction

endpackage

/* rtl/core/quadrature_counter_with_stall_homing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_counter_with_stall_homing
// One-axis x4 quadrature encoder counter with stall-based homing.
//
//   channel | direction | content
//   --------+-----------+----------------------------------------------------
//   s_*     | in        | tuser: command; tdata: enc_a, enc_b
//   m_*     | out       | tdata: position, calibrated, homed_now, settle_armed
//   cfg_*   | in        | 0 stall_window, 1 settle_ms, write only
//
// one result beat per input beat, one beat per cycle sustained while m_tready stays high
// each beat passes through the input register, then the result register
// a stalled result beat lets one more beat into the input register, then s_tready drops
// rst is synchronous; it clears the axis state and both valid flags
// ----------------------------------------------------------------------------
module quadrature_counter_with_stall_homing #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [7:0]                                  s_tdata,  // enc_a, enc_b
  input  logic [1:0]                                  s_tuser,  // command
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // position, calibrated, homed_now, settle_armed
  output logic [((POSITION_BITS + 10) / 8) * 8 - 1:0] m_tdata,
  input  logic                                        cfg_we,
  input  qcsh_pkg::reg_index_t                        cfg_index,
  input  logic [qcsh_pkg::CFG_DATA_BITS-1:0]          cfg_data
);
  import qcsh_pkg::*;

  localparam int TDATA_BITS = ((POSITION_BITS + 10) / 8) * 8;

  logic [WINDOW_BITS-1:0]   stall_window;
  logic [TIMER_BITS-1:0]    settle_ms;

  logic                     in_valid;
  cmd_t                     in_cmd;
  logic                     in_a;
  logic                     in_b;
  logic                     advance;

  logic                     out_valid;
  logic [POSITION_BITS-1:0] out_position;
  qcsh_status_t             out_status;

  logic [POSITION_BITS-1:0] position_next;
  qcsh_status_t             status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_window <= STALL_WINDOW_RESET;
      settle_ms    <= SETTLE_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STALL_WINDOW: stall_window <= cfg_data[WINDOW_BITS-1:0];
        REG_SETTLE_MS:    settle_ms    <= cfg_data[TIMER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= cmd_t'(s_tuser);
      in_a   <= s_tdata[0];
      in_b   <= s_tdata[1];
    end
  end

  qcsh_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .cmd           (in_cmd),
    .enc_a         (in_a),
    .enc_b         (in_b),
    .stall_window  (stall_window),
    .settle_ms     (settle_ms),
    .position_next (position_next),
    .status_next   (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_position <= position_next;
      out_status   <= status_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = TDATA_BITS'({out_status.settle_armed, out_status.homed_now,
                                 out_status.calibrated, out_position});

endmodule

/* rtl/core/qcsh_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcsh_core
// Axis state: x4 quadrature count, settle timer and stall-based homing.
// Gives the result of the presented item and updates state on step.
// ----------------------------------------------------------------------------
module qcsh_core #(
  parameter int POSITION_BITS = 24
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      step,
  input  qcsh_pkg::cmd_t                            cmd,
  input  logic                                      enc_a,
  input  logic                                      enc_b,
  input  logic [qcsh_pkg::WINDOW_BITS-1:0]          stall_window,
  input  logic [qcsh_pkg::TIMER_BITS-1:0]           settle_ms,
  output logic [POSITION_BITS-1:0]                  position_next,
  output qcsh_pkg::qcsh_status_t                    status_next
);
  import qcsh_pkg::*;

  logic [1:0]               prev_ab;
  logic [1:0]               prev_ab_next;
  logic [POSITION_BITS-1:0] count;
  logic [POSITION_BITS-1:0] count_next;
  logic [POSITION_BITS-1:0] last_checked;
  logic [POSITION_BITS-1:0] last_checked_next;
  logic                     armed;
  logic                     armed_next;
  logic [TIMER_BITS-1:0]    elapsed_ms;
  logic [TIMER_BITS-1:0]    elapsed_ms_next;
  logic                     homed;
  logic                     homed_next;

  logic [1:0]               now_ab;
  logic                     count_up;
  logic signed [POSITION_BITS:0] diff;
  logic signed [POSITION_BITS:0] win;
  logic                     in_window;
  logic                     done;

  assign now_ab   = {enc_a, enc_b};
  assign count_up = quad_up({prev_ab, now_ab});

  // full-precision difference so a wrapped count lands far outside the window
  assign diff = $signed({count[POSITION_BITS-1], count}) -
                $signed({last_checked[POSITION_BITS-1], last_checked});
  assign win  = $signed({{(POSITION_BITS + 1 - WINDOW_BITS){1'b0}}, stall_window});
  assign in_window = (diff >= -win) && (diff <= win);

  always_comb begin
    prev_ab_next      = prev_ab;
    count_next        = count;
    last_checked_next = last_checked;
    armed_next        = armed;
    elapsed_ms_next   = elapsed_ms;
    homed_next        = homed;
    done              = 1'b0;
    unique case (cmd)
      CMD_SAMPLE: begin
        if (now_ab != prev_ab) begin
          prev_ab_next = now_ab;
          count_next   = count_up ? count + 1'b1 : count - 1'b1;
        end
      end
      CMD_TICK: begin
        if (armed && (elapsed_ms != TIMER_MAX)) begin
          elapsed_ms_next = elapsed_ms + 1'b1;
        end
      end
      CMD_CHECK: begin
        if (!homed) begin
          if (in_window) begin
            if (!armed) begin
              armed_next      = 1'b1;
              elapsed_ms_next = '0;
            end else if (elapsed_ms >= settle_ms) begin
              count_next = '0;
              homed_next = 1'b1;
              done       = 1'b1;
            end
          end else begin
            armed_next = 1'b0;
          end
          last_checked_next = count_next;
        end
      end
      default: begin
      end
    endcase
  end

  assign position_next            = count_next;
  assign status_next.calibrated   = homed_next;
  assign status_next.homed_now    = done;
  assign status_next.settle_armed = armed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab      <= '0;
      count        <= POSITION_BITS'(COUNT_RESET);
      last_checked <= POSITION_BITS'(LAST_CHECKED_RESET);
      armed        <= 1'b0;
      elapsed_ms   <= '0;
      homed        <= 1'b0;
    end else if (step) begin
      prev_ab      <= prev_ab_next;
      count        <= count_next;
      last_checked <= last_checked_next;
      armed        <= armed_next;
      elapsed_ms   <= elapsed_ms_next;
      homed        <= homed_next;
    end
  end

endmodule

/* rtl/core/qcsh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcsh_checker
// Port-level checks for the quadrature counter, bound to the top level.
// ----------------------------------------------------------------------------
module qcsh_checker #(
  parameter int POSITION_BITS = 24
) (
  input logic                                        clk,
  input logic                                        rst,
  input logic                                        m_tvalid,
  input logic                                        m_tready,
  input logic [((POSITION_BITS + 10) / 8) * 8 - 1:0] m_tdata
);
  logic calib_seen;
  logic out_beat;
  logic beat_calibrated;
  logic beat_homed_now;

  assign out_beat        = m_tvalid && m_tready;
  assign beat_calibrated = m_tdata[POSITION_BITS];
  assign beat_homed_now  = m_tdata[POSITION_BITS + 1];

  // sticky once a delivered beat reports homing done
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_seen <= 1'b0;
    end else if (out_beat && beat_calibrated) begin
      calib_seen <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_homed_calib: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && beat_homed_now |-> beat_calibrated)
    else $error("homing beat without calibrated");

  a_homed_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && beat_homed_now |-> m_tdata[POSITION_BITS-1:0] == '0)
    else $error("homing beat with non-zero position");

  a_calib_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && calib_seen |-> beat_calibrated && !beat_homed_now)
    else $error("calibrated dropped or homing repeated");

endmodule

bind quadrature_counter_with_stall_homing qcsh_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_qcsh_checker (.*);
